/* hdl/dmk_pkg.sv */
// shared types and constants for the dual monod cell kinetics core
// no dependencies; imported by all modules
package dmk_pkg;

	localparam int unsigned FRAC_W = 17;   // x/(k+x) in q16.16, at most 1.0
	localparam int unsigned MAG_W  = 48;   // saturated intermediate magnitude
	localparam int unsigned SUM_W  = 51;   // exact accumulator sums

	localparam logic [MAG_W-1:0] CAP48 = 48'hFFFF_FFFF_FFFF;

	// q16.16 constants, the dissolution rate is q0.32
	localparam logic [13:0] K_0P2   = 14'd13107;
	localparam logic [12:0] K_0P1   = 13'd6554;
	localparam logic [15:0] K_0P727 = 16'd47645;
	localparam logic [15:0] K_0P65  = 16'd42598;
	localparam logic [14:0] K_DISS  = 15'd18898;

	// mode_flags bits
	localparam int unsigned MODE_REAC = 0;
	localparam int unsigned MODE_GROW = 1;
	localparam int unsigned MODE_DISS = 2;

	typedef enum logic [2:0] {
		REG_MAX_GROWTH,
		REG_LIGHT_AFF,
		REG_CO2_AFF,
		REG_INV_YIELD,
		REG_MAINT,
		REG_DECAY,
		REG_SUC_EXPORT,
		REG_MODE
	} reg_idx_t;

	typedef struct packed {
		logic        [31:0] light_conc;
		logic        [31:0] co2_conc;
		logic        [31:0] gas_co2_conc;
		logic        [31:0] biomass_density;
		logic               ghost_cell;
		logic signed [31:0] light_reac_in;
		logic signed [31:0] co2_reac_in;
		logic signed [31:0] o2_reac_in;
		logic signed [31:0] sucrose_reac_in;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] light_reac_out;
		logic signed [31:0] co2_reac_out;
		logic signed [31:0] o2_reac_out;
		logic signed [31:0] sucrose_reac_out;
		logic signed [31:0] net_growth;
	} out_word_t;

endpackage

/* hdl/dmk_chan_if.sv */
// valid/ready channel carrying one word of a given type
// depends on nothing; the word types come from dmk_pkg
interface dmk_chan_if #(parameter type word_t = logic) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/dmk_frac_div.sv */
// pipelined restoring divider for (x<<16)/(x+k), one quotient bit a stage
// depends on dmk_pkg; every stage advances only while en is high
module dmk_frac_div import dmk_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [31:0]       x,
	input  logic [31:0]       k,
	output logic [FRAC_W-1:0] q
);

	localparam int unsigned NSTG  = FRAC_W;
	localparam int unsigned REM_W = 50;

	logic [REM_W-1:0]  rem_s  [0:NSTG-1];
	logic [32:0]       den_s  [0:NSTG-1];
	logic [FRAC_W-1:0] quo_s  [0:NSTG];
	logic              zero_s [0:NSTG];

	// form the denominator and the scaled numerator
	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= 33'(x) + 33'(k);
			rem_s[0]  <= {2'b00, x, 16'h0000};
			quo_s[0]  <= '0;
			zero_s[0] <= (x == 32'd0) && (k == 32'd0);
		end
	end

	// one trial subtract per stage, msb first
	for (genvar j = 1; j <= NSTG; j++) begin : g_bit
		localparam int unsigned SH = NSTG - j;
		logic [REM_W-1:0] trial;
		logic             take;

		assign trial = REM_W'(den_s[j-1]) << SH;
		assign take  = rem_s[j-1] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[j]  <= quo_s[j-1] | (FRAC_W'(take) << SH);
				zero_s[j] <= zero_s[j-1];
			end
		end

		if (j < NSTG) begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= take ? rem_s[j-1] - trial : rem_s[j-1];
					den_s[j] <= den_s[j-1];
				end
			end
		end
	end

	// zero denominator reads as a zero fraction
	assign q = zero_s[NSTG] ? '0 : quo_s[NSTG];

endmodule

/* hdl/dmk_qmul.sv */
// saturating q16.16 product of a 32 bit and a 48 bit magnitude
// depends on dmk_pkg; registered partial products, then a registered clamp, both held while en is low
module dmk_qmul import dmk_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [31:0]      a,
	input  logic [MAG_W-1:0] b,
	output logic [MAG_W-1:0] p
);

	logic [55:0]      hi_s1;
	logic [55:0]      lo_s1;
	logic [79:0]      full;
	logic [MAG_W-1:0] prod_s2;

	// partial products on the upper and lower halves of b
	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1 <= 56'(a) * 56'(b[47:24]);
			lo_s1 <= 56'(a) * 56'(b[23:0]);
		end
	end

	assign full = {hi_s1, 24'h000000} + 80'(lo_s1);

	// shift out the fraction and clamp
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= (full[79:64] != 16'h0000) ? CAP48 : full[63:16];
		end
	end

	assign p = prod_s2;

endmodule

/* hdl/dual_monod_cell_kinetics_core.sv */
// top level of the dual monod cell kinetics core: config registers and pipeline
// depends on dmk_pkg, dmk_chan_if, dmk_frac_div and dmk_qmul
//
//   channel   direction  word         handshake
//   cell_in   in         in_word_t    valid/ready
//   cell_out  out        out_word_t   valid/ready
//   apb       in/out     32 bit regs  psel/penable, pready tied high
//
// one word accepted per cycle while cell_out is not stalled; a word passes
// through the fraction dividers and the split 48 bit products on its way to
// the output register. all stages move on one enable, so a stall on cell_out
// freezes the whole pipe and nothing is lost or repeated. reset clears the
// valid bits and loads the register defaults.
module dual_monod_cell_kinetics_core import dmk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	dmk_chan_if.sink    cell_in,
	dmk_chan_if.source  cell_out
);

	localparam logic signed [SUM_W-1:0] SAT_HI = 51'sd2147483647;
	localparam logic signed [SUM_W-1:0] SAT_LO = -51'sd2147483648;

	typedef struct packed {
		logic        [31:0] dens;
		logic               ghost;
		logic signed [31:0] acc_l;
		logic signed [31:0] acc_c;
		logic signed [31:0] acc_o;
		logic signed [31:0] acc_s;
		logic signed [16:0] diss;
	} side_t;

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) r = 32'sh7FFF_FFFF;
		else if (v < SAT_LO) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	// configuration registers
	logic [31:0] max_growth_q, light_aff_q, co2_aff_q, inv_yield_q;
	logic [31:0] maint_q, decay_q, suc_export_q;
	logic [2:0]  mode_q;
	reg_idx_t    reg_idx;

	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_growth_q <= 32'd0;
			light_aff_q  <= 32'h0001_0000;
			co2_aff_q    <= 32'h0001_0000;
			inv_yield_q  <= 32'h0001_0000;
			maint_q      <= 32'd0;
			decay_q      <= 32'd0;
			suc_export_q <= 32'd0;
			mode_q       <= 3'd3;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_MAX_GROWTH: max_growth_q <= pwdata;
				REG_LIGHT_AFF:  light_aff_q  <= pwdata;
				REG_CO2_AFF:    co2_aff_q    <= pwdata;
				REG_INV_YIELD:  inv_yield_q  <= pwdata;
				REG_MAINT:      maint_q      <= pwdata;
				REG_DECAY:      decay_q      <= pwdata;
				REG_SUC_EXPORT: suc_export_q <= pwdata;
				REG_MODE:       mode_q       <= pwdata[2:0];
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_MAX_GROWTH: prdata = max_growth_q;
			REG_LIGHT_AFF:  prdata = light_aff_q;
			REG_CO2_AFF:    prdata = co2_aff_q;
			REG_INV_YIELD:  prdata = inv_yield_q;
			REG_MAINT:      prdata = maint_q;
			REG_DECAY:      prdata = decay_q;
			REG_SUC_EXPORT: prdata = suc_export_q;
			REG_MODE:       prdata = 32'(mode_q);
		endcase
	end

	// pipeline enable and valid bits
	logic en;
	logic vld_s [1:31];

	assign en            = !vld_s[31] || cell_out.ready;
	assign cell_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= 31; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= cell_in.valid;
			for (int i = 2; i <= 31; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// input word register
	in_word_t item_s1;

	always_ff @(posedge clk) begin
		if (en) item_s1 <= cell_in.data;
	end

	// co2 dissolution term, truncated toward zero
	logic [31:0]        diss_mag;
	logic               diss_neg;
	logic [46:0]        diss_prod;
	logic signed [16:0] diss_val;

	always_comb begin
		diss_neg  = item_s1.gas_co2_conc < item_s1.co2_conc;
		diss_mag  = diss_neg ? item_s1.co2_conc - item_s1.gas_co2_conc
		                     : item_s1.gas_co2_conc - item_s1.co2_conc;
		diss_prod = 47'(diss_mag) * 47'(K_DISS);
		diss_val  = diss_neg ? -17'(diss_prod[46:32]) : 17'(diss_prod[46:32]);
	end

	// per word side data riding along the pipe
	side_t side_s [2:29];

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[2].dens  <= item_s1.biomass_density;
			side_s[2].ghost <= item_s1.ghost_cell;
			side_s[2].acc_l <= item_s1.light_reac_in;
			side_s[2].acc_c <= item_s1.co2_reac_in;
			side_s[2].acc_o <= item_s1.o2_reac_in;
			side_s[2].acc_s <= item_s1.sucrose_reac_in;
			side_s[2].diss  <= diss_val;
			for (int i = 3; i <= 29; i++) side_s[i] <= side_s[i-1];
		end
	end

	// light and co2 fractions
	logic [FRAC_W-1:0] fl_s19, fc_s19;

	dmk_frac_div u_div_light (
		.clk (clk),
		.en  (en),
		.x   (item_s1.light_conc),
		.k   (light_aff_q),
		.q   (fl_s19)
	);

	dmk_frac_div u_div_co2 (
		.clk (clk),
		.en  (en),
		.x   (item_s1.co2_conc),
		.k   (co2_aff_q),
		.q   (fc_s19)
	);

	// growth rate g and export terms
	logic [48:0]       mul_a, mul_g;
	logic [63:0]       mul_ge;
	logic [61:0]       mul_t2;
	logic [48:0]       add_bs;
	logic [44:0]       mul_m1;
	logic [31:0]       a_s20, g_s21, g_s22, g_s23, g_s24;
	logic [FRAC_W-1:0] fc_s20;
	logic [MAG_W-1:0]  ge_s22, t3_s23, t3_s24, bsum_s24;
	logic [45:0]       t2_s23;
	logic [48:0]       neg1_s24;
	logic [32:0]       neg2_s24;
	logic [28:0]       m1_s24, m1_s25, m1_s26;

	assign mul_a  = 49'(max_growth_q) * 49'(fl_s19);
	assign mul_g  = 49'(a_s20) * 49'(fc_s20);
	assign mul_ge = 64'(g_s21) * 64'(suc_export_q);
	assign mul_t2 = 62'(ge_s22) * 62'(K_0P2);
	assign add_bs = 49'(g_s23) + 49'(t3_s23);
	assign mul_m1 = 45'(maint_q) * 45'(K_0P1);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s20    <= mul_a[47:16];
			fc_s20   <= fc_s19;
			g_s21    <= mul_g[47:16];
			g_s22    <= g_s21;
			ge_s22   <= mul_ge[63:16];
			g_s23    <= g_s22;
			t2_s23   <= mul_t2[61:16];
			t3_s23   <= (ge_s22[47:46] != 2'b00) ? CAP48 : {ge_s22[45:0], 2'b00};
			g_s24    <= g_s23;
			t3_s24   <= t3_s23;
			bsum_s24 <= add_bs[48] ? CAP48 : add_bs[47:0];
			neg1_s24 <= 49'(t2_s23) + 49'(t3_s23);
			neg2_s24 <= 33'(decay_q) + 33'(maint_q);
			m1_s24   <= mul_m1[44:16];
			m1_s25   <= m1_s24;
			m1_s26   <= m1_s25;
		end
	end

	// net growth before the growth gate
	logic signed [SUM_W-1:0] net_s [25:29];

	always_ff @(posedge clk) begin
		if (en) begin
			net_s[25] <= SUM_W'(g_s24) - SUM_W'(neg1_s24) - SUM_W'(neg2_s24);
			for (int i = 26; i <= 29; i++) net_s[i] <= net_s[i-1];
		end
	end

	// uptake products through the yield and the density
	logic [MAG_W-1:0] u1_s26, v1_s26, u_s28, v_s28;

	dmk_qmul u_mul_u1 (.clk(clk), .en(en), .a(inv_yield_q), .b(bsum_s24), .p(u1_s26));
	dmk_qmul u_mul_v1 (.clk(clk), .en(en), .a(inv_yield_q), .b(t3_s24), .p(v1_s26));
	dmk_qmul u_mul_u  (.clk(clk), .en(en), .a(side_s[26].dens), .b(u1_s26), .p(u_s28));
	dmk_qmul u_mul_v  (.clk(clk), .en(en), .a(side_s[26].dens), .b(v1_s26), .p(v_s28));

	// maintenance, evolution and export terms
	logic [60:0]      mul_m;
	logic [63:0]      mul_e, mul_s;
	logic [44:0]      m_s27, m_s28, m_s29;
	logic [MAG_W-1:0] u_s29, e_s29, s_s29;

	assign mul_m = 61'(m1_s26) * 61'(side_s[26].dens);
	assign mul_e = 64'(u_s28) * 64'(K_0P727);
	assign mul_s = 64'(v_s28) * 64'(K_0P65);

	always_ff @(posedge clk) begin
		if (en) begin
			m_s27 <= mul_m[60:16];
			m_s28 <= m_s27;
			m_s29 <= m_s28;
			u_s29 <= u_s28;
			e_s29 <= mul_e[63:16];
			s_s29 <= mul_s[63:16];
		end
	end

	// accumulator sums, gated by mode and ghost flag
	logic                    reac_act, diss_act, grow_on;
	logic signed [SUM_W-1:0] light_s30, co2_s30, o2_s30, suc_s30, net_s30;

	assign grow_on  = mode_q[MODE_GROW];
	assign reac_act = mode_q[MODE_REAC] && !side_s[29].ghost;
	assign diss_act = mode_q[MODE_DISS] && (mode_q[MODE_REAC] || mode_q[MODE_GROW]);

	always_ff @(posedge clk) begin
		if (en) begin
			light_s30 <= SUM_W'(side_s[29].acc_l) - (reac_act ? SUM_W'(u_s29) : '0);
			co2_s30   <= SUM_W'(side_s[29].acc_c) - (reac_act ? SUM_W'(u_s29) : '0)
			             + (diss_act ? SUM_W'(side_s[29].diss) : '0);
			o2_s30    <= SUM_W'(side_s[29].acc_o)
			             + (reac_act ? SUM_W'(e_s29) - SUM_W'(m_s29) : '0);
			suc_s30   <= SUM_W'(side_s[29].acc_s) + (reac_act ? SUM_W'(s_s29) : '0);
			net_s30   <= grow_on ? net_s[29] : '0;
		end
	end

	// output register with saturation
	out_word_t out_s31;

	always_ff @(posedge clk) begin
		if (en) begin
			out_s31.light_reac_out   <= sat32(light_s30);
			out_s31.co2_reac_out     <= sat32(co2_s30);
			out_s31.o2_reac_out      <= sat32(o2_s30);
			out_s31.sucrose_reac_out <= sat32(suc_s30);
			out_s31.net_growth       <= sat32(net_s30);
		end
	end

	assign cell_out.valid = vld_s[31];
	assign cell_out.data  = out_s31;

endmodule

/* sim/dmk_checker.sv */
`timescale 1ns / 100ps
// scoreboard for the dual monod cell kinetics core: tracks apb writes, predicts each word
// depends on dmk_pkg; watches the cell channels and the apb port beside the block
module dmk_checker import dmk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_word_t    in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_word_t   out_data,
	output int          errors,
	output int          pending
);

	localparam logic [63:0] CAP = 64'h0000_FFFF_FFFF_FFFF;

	logic [31:0] mu_max, k_light, k_co2, yield_inv, maint, decay, export_frac;
	logic [2:0]  mode;
	out_word_t   kinetics_q[$];

	assign pending = kinetics_q.size();

	// saturating q16.16 product of two capped magnitudes
	function automatic logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		if (a > CAP) a = CAP;
		if (b > CAP) b = CAP;
		p = (a * b) >> 16;
		return (p > CAP) ? CAP : p[63:0];
	endfunction

	// x/(k+x) in q16.16, zero on a zero denominator
	function automatic logic [63:0] monod(logic [31:0] x, logic [31:0] k);
		logic [63:0] d;
		d = {32'd0, x} + {32'd0, k};
		if (d == 0) return 0;
		return ({32'd0, x} << 16) / d;
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic out_word_t cell_kinetics(in_word_t w);
		out_word_t   r;
		logic [63:0] g, ge, t2, t3, u, m, e, s, d, dens;
		longint      al, ac, ao, asu, net;
		al = longint'(w.light_reac_in);
		ac = longint'(w.co2_reac_in);
		ao = longint'(w.o2_reac_in);
		asu = longint'(w.sucrose_reac_in);
		net = 0;
		dens = {32'd0, w.biomass_density};
		if (mode[MODE_REAC] || mode[MODE_GROW]) begin
			g = sat_mul(sat_mul({32'd0, mu_max}, monod(w.light_conc, k_light)),
				monod(w.co2_conc, k_co2));
			ge = sat_mul(g, {32'd0, export_frac});
			t2 = sat_mul(64'd13107, ge);
			t3 = sat_mul(64'd262144, ge);
			// uptake, evolution and export skip ghost cells
			if (mode[MODE_REAC] && !w.ghost_cell) begin
				u = sat_mul(sat_mul({32'd0, yield_inv}, g + t3), dens);
				m = sat_mul(sat_mul(64'd6554, {32'd0, maint}), dens);
				e = sat_mul(64'd47645, u);
				s = sat_mul(64'd42598, sat_mul(sat_mul({32'd0, yield_inv}, t3), dens));
				al -= longint'(u);
				ac -= longint'(u);
				ao += longint'(e) - longint'(m);
				asu += longint'(s);
			end
			// dissolution, truncated toward zero
			if (mode[MODE_DISS]) begin
				if (w.gas_co2_conc >= w.co2_conc) begin
					d = ({32'd0, w.gas_co2_conc - w.co2_conc} * 64'd18898) >> 32;
					ac += longint'(d);
				end else begin
					d = ({32'd0, w.co2_conc - w.gas_co2_conc} * 64'd18898) >> 32;
					ac -= longint'(d);
				end
			end
			if (mode[MODE_GROW])
				net = longint'(g) - longint'(t2) - longint'(t3)
					- longint'({32'd0, decay}) - longint'({32'd0, maint});
		end
		r.light_reac_out = clamp32(al);
		r.co2_reac_out = clamp32(ac);
		r.o2_reac_out = clamp32(ao);
		r.sucrose_reac_out = clamp32(asu);
		r.net_growth = clamp32(net);
		return r;
	endfunction

	task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// register copy, updated on the apb access edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_max <= '0;
			k_light <= 32'd65536;
			k_co2 <= 32'd65536;
			yield_inv <= 32'd65536;
			maint <= '0;
			decay <= '0;
			export_frac <= '0;
			mode <= 3'd3;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_MAX_GROWTH: mu_max <= pwdata;
				REG_LIGHT_AFF:  k_light <= pwdata;
				REG_CO2_AFF:    k_co2 <= pwdata;
				REG_INV_YIELD:  yield_inv <= pwdata;
				REG_MAINT:      maint <= pwdata;
				REG_DECAY:      decay <= pwdata;
				REG_SUC_EXPORT: export_frac <= pwdata;
				REG_MODE:       mode <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// predict on accepted input words, compare on accepted output words
	initial errors = 0;
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n) begin
			if (in_valid && in_ready)
				kinetics_q.push_back(cell_kinetics(in_data));
			if (out_valid && out_ready) begin
				if (kinetics_q.size() == 0) begin
					$error("unexpected output word %h", out_data);
					errors++;
				end else begin
					exp_w = kinetics_q.pop_front();
					cmp_field("light_reac_out", exp_w.light_reac_out, out_data.light_reac_out);
					cmp_field("co2_reac_out", exp_w.co2_reac_out, out_data.co2_reac_out);
					cmp_field("o2_reac_out", exp_w.o2_reac_out, out_data.o2_reac_out);
					cmp_field("sucrose_reac_out", exp_w.sucrose_reac_out,
						out_data.sucrose_reac_out);
					cmp_field("net_growth", exp_w.net_growth, out_data.net_growth);
				end
			end
		end
	end

endmodule

/* sim/tb_dual_monod_cell_kinetics_core.sv */
`timescale 1ns / 100ps
// testbench top for dual_monod_cell_kinetics_core: clock, reset, apb setup and cell stimulus
// depends on dmk_pkg, dmk_chan_if, the core and dmk_checker
module tb_dual_monod_cell_kinetics_core import dmk_pkg::*; ();

	localparam int DRAIN_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite, pready;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          errors, pending;
	int          idle_pct, stall_pct;
	logic        hold_out;

	dmk_chan_if #(.word_t(in_word_t))  in_ch ();
	dmk_chan_if #(.word_t(out_word_t)) out_ch ();

	dual_monod_cell_kinetics_core u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cell_in(in_ch), .cell_out(out_ch)
	);

	dmk_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.errors(errors), .pending(pending)
	);

	// clock
	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// receiver side, with random stalls and an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !hold_out && ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog
	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// valid stays up between back-to-back words, drops only while idling
	task automatic send_cell(in_word_t w);
		if ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// let every expected word come out before touching registers
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick32();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(32'h0004_0000);
			3: return 32'h8000_0000 ^ $urandom_range(255);
			4: return $urandom_range(32'h0100_0000);
			default: return $urandom();
		endcase
	endfunction

	function automatic in_word_t rand_cell();
		in_word_t w;
		w.light_conc = pick32();
		w.co2_conc = pick32();
		w.gas_co2_conc = pick32();
		w.biomass_density = pick32();
		w.ghost_cell = ($urandom_range(3) == 0);
		w.light_reac_in = pick32();
		w.co2_reac_in = pick32();
		w.o2_reac_in = pick32();
		w.sucrose_reac_in = pick32();
		return w;
	endfunction

	function automatic in_word_t make_cell(logic [31:0] l, logic [31:0] c, logic [31:0] gc,
			logic [31:0] dn, logic gh, logic [31:0] acc);
		in_word_t w;
		w = '{l, c, gc, dn, gh, acc, acc, acc, acc};
		return w;
	endfunction

	task automatic set_regs(logic [31:0] mg, logic [31:0] kl, logic [31:0] kc,
			logic [31:0] yi, logic [31:0] mt, logic [31:0] dc, logic [31:0] se,
			logic [2:0] md);
		reg_write(REG_MAX_GROWTH, mg);
		reg_write(REG_LIGHT_AFF, kl);
		reg_write(REG_CO2_AFF, kc);
		reg_write(REG_INV_YIELD, yi);
		reg_write(REG_MAINT, mt);
		reg_write(REG_DECAY, dc);
		reg_write(REG_SUC_EXPORT, se);
		reg_write(REG_MODE, {29'd0, md});
	endtask

	initial begin
		int mode_sel;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_ch.valid = 0; in_ch.data = '0;
		hold_out = 0; idle_pct = 0; stall_pct = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed words: all modes, ghost, extremes, both dissolution signs
		for (int md = 0; md < 8; md++) begin
			set_regs(32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000,
				32'h0000_1000, 32'h0000_0800, 32'h0000_4000, md[2:0]);
			send_cell(make_cell(32'h0001_0000, 32'h0001_0000, 32'h00F0_0000,
				32'h0010_0000, 1'b0, 32'd0));
			send_cell(make_cell(32'h0001_0000, 32'h00F0_0000, 32'h0000_0000,
				32'h0010_0000, 1'b1, 32'h7FFF_FFFF));
			drain();
		end
		set_regs('1, 32'd1, 32'd1, '1, '1, '1, '1, 3'd7);
		send_cell(make_cell('1, '1, '1, '1, 1'b0, 32'h8000_0000));
		send_cell(make_cell('1, '1, 32'd0, '1, 1'b1, 32'h7FFF_FFFF));
		send_cell(make_cell(32'd0, 32'd0, '1, 32'd0, 1'b0, 32'd0));
		drain();
		// zero affinity with zero concentration
		set_regs(32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 3'd7);
		send_cell(make_cell(32'd0, 32'd0, 32'd0, 32'h0001_0000, 1'b0, 32'd0));
		send_cell(make_cell(32'h0001_0000, 32'd0, 32'h0001_0000, '1, 1'b0, 32'd0));
		drain();

		// random phases over several register settings and idling patterns
		for (int ph = 0; ph < 12; ph++) begin
			mode_sel = ph % 4;
			case (mode_sel)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 78; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 78; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			case (ph)
				0: set_regs(32'h0001_8000, 32'h0000_4000, 32'h0000_2000, 32'h0001_0000,
					32'h0000_0100, 32'h0000_0080, 32'h0000_2000, 3'd7);
				1: set_regs('1, 32'd1, 32'd1, '1, '1, '1, '1, 3'd7);
				2: set_regs(32'd0, '1, '1, 32'd0, 32'd0, 32'd0, 32'd0, 3'd3);
				default: set_regs(pick32(), pick32() | 32'd1, pick32() | 32'd1, pick32(),
					pick32(), pick32(), pick32(), 3'($urandom_range(7)));
			endcase
			if (ph == 4) begin
				// long receiver hold-off while words keep coming
				fork
					begin
						@(posedge clk);
						hold_out <= 1'b1;
						repeat (300) @(posedge clk);
						hold_out <= 1'b0;
					end
				join_none
			end
			for (int i = 0; i < 100; i++)
				send_cell(rand_cell());
			drain();
		end

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
